### hw/rtl/esc_enc_pkg.sv
// Package: word types, protocol codes and constants for the motor output encoder.
package esc_enc_pkg;

  localparam int MotorCount = 4;
  localparam int QueueDepth = 2;
  localparam int FrameBits  = 16;
  localparam int FrameWords = 18;

  localparam logic [1:0] ModeDshot   = 2'd0;
  localparam logic [1:0] ModeOneshot = 2'd1;
  localparam logic [1:0] ModeMulti   = 2'd2;

  localparam logic [8:0]  BitOneTicks  = 9'd30;
  localparam logic [8:0]  BitZeroTicks = 9'd15;
  localparam logic [8:0]  NoTicks      = 9'd0;
  localparam logic [10:0] ThrMin       = 11'd48;
  localparam logic [8:0]  Os125Base    = 9'd125;
  localparam logic [8:0]  MsBase       = 9'd60;

  // Floor division by the throttle span (1999) as a multiply by a rounded-up
  // reciprocal, exact for every dividend below 2^19.
  localparam int      DivShift = 30;
  localparam longint  ThrSpan  = 1999;
  localparam longint  Recip    = ((64'd1 << DivShift) + ThrSpan - 1) / ThrSpan;
  localparam logic [26:0] KOneshot = 27'(125 * Recip);
  localparam logic [26:0] KMulti   = 27'(240 * Recip);

  typedef struct packed {
    logic [1:0]  motor_index;
    logic [10:0] throttle;
  } in_word_t;

  typedef struct packed {
    logic [1:0] out_motor;
    logic [4:0] slot_index;
    logic [8:0] compare_value;
    logic       last_word;
  } out_word_t;

  // One classified item waiting for the back end.
  typedef struct packed {
    logic [1:0]  motor;
    logic        is_frame;
    logic [15:0] data;
  } task_t;

endpackage

### hw/rtl/esc_enc_front.sv
// Front end: accepts input words, builds the DShot frame or the pulse width.
module esc_enc_front import esc_enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       push_valid_o,
  input  logic       push_full_i,
  output task_t      push_task_o
);

  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_motor_q;
  logic        s1_is_frame_q;
  logic [15:0] s1_frame_q;
  logic [37:0] s1_prod_q;
  logic [8:0]  s1_base_q;

  logic        s1_adv;
  logic        accept;
  logic        keep;
  logic [11:0] payload;
  logic [3:0]  csum;
  logic [10:0] delta;
  logic [26:0] kval;
  logic [8:0]  pulse;

  assign s1_adv     = !s1_valid_q || !push_full_i;
  assign in_stall_o = !s1_adv;
  assign accept     = in_valid_i && s1_adv;
  assign keep       = (32'(in_word_i.motor_index) < MotorCount) &&
                      (mode_i == ModeDshot || mode_i == ModeOneshot || mode_i == ModeMulti);

  assign payload = {in_word_i.throttle, 1'b0};
  assign csum    = payload[3:0] ^ payload[7:4] ^ payload[11:8];
  assign delta   = (in_word_i.throttle > ThrMin) ? (in_word_i.throttle - ThrMin) : 11'd0;
  assign kval    = (mode_i == ModeMulti) ? KMulti : KOneshot;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = accept && keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_motor_q    <= in_word_i.motor_index;
      s1_is_frame_q <= (mode_i == ModeDshot);
      s1_frame_q    <= {payload, csum};
      s1_prod_q     <= 38'(delta) * 38'(kval);
      s1_base_q     <= (mode_i == ModeMulti) ? MsBase : Os125Base;
    end
  end

  assign pulse = s1_base_q + {1'b0, s1_prod_q[37:DivShift]};

  assign push_valid_o         = s1_valid_q;
  assign push_task_o.motor    = s1_motor_q;
  assign push_task_o.is_frame = s1_is_frame_q;
  assign push_task_o.data     = s1_is_frame_q ? s1_frame_q : {7'd0, pulse};

endmodule

### hw/rtl/esc_enc_queue.sv
// Short queue of classified items between the front and back ends.
module esc_enc_queue import esc_enc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  task_t push_task_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output task_t head_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  task_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_task_i;
    end
  end

endmodule

### hw/rtl/esc_enc_back.sv
// Back end: turns each queued item into compare words, one per cycle unless stalled.
module esc_enc_back import esc_enc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      task_valid_i,
  input  task_t     task_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic       out_valid_q, out_valid_d;
  out_word_t  out_word_q;
  logic [4:0] slot_q, slot_d;

  logic       out_adv;
  logic       emit;
  logic       last;
  logic [8:0] cmp;

  assign out_adv = !out_valid_q || !out_stall_i;
  assign emit    = task_valid_i && out_adv;
  assign last    = !task_i.is_frame || (slot_q == 5'(FrameWords - 1));
  assign pop_o   = emit && last;

  always_comb begin
    cmp = task_i.data[8:0];
    if (task_i.is_frame) begin
      if (slot_q < 5'(FrameBits)) begin
        cmp = task_i.data[4'(FrameBits - 1) - slot_q[3:0]] ? BitOneTicks : BitZeroTicks;
      end else begin
        cmp = NoTicks;
      end
    end
  end

  always_comb begin
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = task_valid_i;
    end
    if (emit) begin
      slot_d = last ? 5'd0 : slot_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      slot_q      <= 5'd0;
    end else begin
      out_valid_q <= out_valid_d;
      slot_q      <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q.out_motor     <= task_i.motor;
      out_word_q.slot_index    <= slot_q;
      out_word_q.compare_value <= cmp;
      out_word_q.last_word     <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### hw/rtl/esc_motor_output_encoder.sv
// Top level of the motor output encoder: DShot300 frames and Oneshot/Multishot pulses.
//
// An input word (motor number, throttle) is taken when in_valid_i is high and
// in_stall_o is low. The protocol register is written through cfg_valid_i and
// cfg_data_i; cfg_ready_o is always high. The user must make writes only while
// the block is idle; the block does not enforce this. The front end builds the
// 16-bit DShot frame or the pulse width (one multiply by a reciprocal in its
// single stage) and places the item in a two-entry queue. The back end drains
// the queue into an output register. In DShot mode each item gives 18 words (16 bit
// slots, two zero slots); pulse modes give one word per item and run at one item
// per cycle while the output is not stalled. An item passes through the front-end
// register and a queue entry before its first word is loaded into the output
// register. Items for the unused protocol code give no words. A word is taken when
// out_valid_o is high and out_stall_i is low; while the receiver stalls the word
// holds, and the front end keeps taking items until the queue is full and its own
// stage holds an item. Reset clears all valid state and selects DShot300.
module esc_motor_output_encoder import esc_enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  logic [1:0] mode_q;
  logic       push_valid;
  logic       push_full;
  task_t      push_task;
  logic       head_valid;
  task_t      head_task;
  logic       pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeDshot;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  esc_enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .push_valid_o (push_valid),
    .push_full_i  (push_full),
    .push_task_o  (push_task)
  );

  esc_enc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_task_i (push_task),
    .full_o      (push_full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head_task)
  );

  esc_enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_valid_i (head_valid),
    .task_i       (head_task),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule
